[rtl/assert_macros.svh]
// Assertion helpers shared by the matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold prop on every clock edge outside reset.
`define DHM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DHM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/dhm_pkg.sv]
package dhm_pkg;

  localparam int PATTERN_MAX_DEF = 1024;
  localparam int SYM_W = 2;
  localparam int CFG_W = 11;
  localparam int IDX_W = 10;
  localparam int CNT_W = 32;
  localparam int REG_IDX_W = 2;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_HOLES = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_HOLE_LEN = 2'd2;

  localparam logic FUNC_PATTERN = 1'b0;
  localparam logic FUNC_SEQUENCE = 1'b1;

  typedef struct packed {
    logic shift_up;
    logic shift_dn;
  } cell_ctl_t;

  typedef struct packed {
    logic [CFG_W-1:0] run_count_lim;
    logic [CFG_W-1:0] max_hole_len;
  } hole_lim_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_DRAIN,
    ST_RESTORE,
    ST_EMIT
  } state_t;

endpackage

[rtl/dhm_in_if.sv]
interface dhm_in_if;
  import dhm_pkg::*;
  logic valid;
  logic ready;
  logic func;
  logic [IDX_W-1:0] pattern_index;
  logic [SYM_W-1:0] symbol;
  logic new_sequence;

  modport source (output valid, func, pattern_index, symbol, new_sequence, input ready);
  modport sink (input valid, func, pattern_index, symbol, new_sequence, output ready);
endinterface

[rtl/dhm_out_if.sv]
interface dhm_out_if;
  import dhm_pkg::*;
  logic valid;
  logic ready;
  logic [CNT_W-1:0] match_position;
  logic forward_hit;
  logic reverse_hit;
  logic [CNT_W-1:0] match_count;

  modport source (output valid, match_position, forward_hit, reverse_hit, match_count,
                  input ready);
  modport sink (input valid, match_position, forward_hit, reverse_hit, match_count,
                output ready);
endinterface

[rtl/dhm_ram.sv]
module dhm_ram #(
  parameter int W = 2,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/dhm_cell.sv]
module dhm_cell
  import dhm_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [SYM_W-1:0] lo_in,
  input  logic [SYM_W-1:0] hi_in,
  output logic [SYM_W-1:0] q
);
  logic [SYM_W-1:0] sym_r, sym_nxt;

  always_comb begin
    sym_nxt = sym_r;
    if (ctl.shift_up) begin
      sym_nxt = lo_in;
    end else if (ctl.shift_dn) begin
      sym_nxt = hi_in;
    end
  end

  always_ff @(posedge clk) begin
    sym_r <= sym_nxt;
  end

  assign q = sym_r;
endmodule

[rtl/dhm_hole.sv]
module dhm_hole
  import dhm_pkg::*;
#(
  parameter int LW = 11
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      clear,
  input  logic      valid,
  input  logic      mismatch,
  input  hole_lim_t lim,
  output logic      fail
);
  logic [LW-1:0] run_r, run_nxt;
  logic [LW-1:0] runs_r, runs_nxt;
  logic          fail_r, fail_nxt;

  always_comb begin
    run_nxt  = run_r;
    runs_nxt = runs_r;
    fail_nxt = fail_r;
    if (clear) begin
      run_nxt  = '0;
      runs_nxt = '0;
      fail_nxt = 1'b0;
    end else if (valid && !fail_r) begin
      if (mismatch) begin
        run_nxt = run_r + LW'(1);
        if (run_r == '0) begin
          runs_nxt = runs_r + LW'(1);
        end
        if (32'(run_nxt) > 32'(lim.max_hole_len) || 32'(runs_nxt) > 32'(lim.run_count_lim)) begin
          fail_nxt = 1'b1;
        end
      end else begin
        run_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= '0;
      runs_r <= '0;
      fail_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      runs_r <= runs_nxt;
      fail_r <= fail_nxt;
    end
  end

  assign fail = fail_r;
endmodule

[rtl/dna_hole_tolerant_pattern_matcher.sv]
// Pattern write: lands in both pattern RAMs. Symbol before a full window: shifted in, back to idle.
// Full window: CMP, DRAIN and RESTORE walk it (L = active pattern length), then EMIT on a hit.
// The window ring walks L steps past the compare tap and L steps back through the cell chain.
// Throughput: one transaction at a time; a new one is accepted once back in idle.
// Reset (synchronous, rst_n low): counters cleared, pattern_length 1, hole limits 0.
// Pattern store and window contents are undefined until written.
`include "assert_macros.svh"
module dna_hole_tolerant_pattern_matcher
  import dhm_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  dhm_in_if.sink               in_ch,
  dhm_out_if.source            out_ch
);
  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int AW = $clog2(PATTERN_MAX);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] plen_r, mh_r, mhl_r;
  logic [CNT_W-1:0] seen_r, seen_nxt, matches_r, matches_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [LW-1:0]    k_r, k_nxt;
  logic [SYM_W-1:0] tap_r;
  logic             cmp_v_r, cmp_v_nxt;

  logic             out_v_r, out_v_nxt;
  logic [CNT_W-1:0] out_pos_r, out_cnt_r;
  logic             out_fwd_r, out_rev_r;

  logic [CNT_W-1:0] len32;
  logic [LW-1:0]    len_l;
  logic             acc, acc_seq, acc_pat;
  logic [CNT_W-1:0] seen_base;
  logic             win_full;
  logic             k_last;
  logic             trk_clear;
  logic             fail_f, fail_r;
  logic             load_out;
  logic [CNT_W-1:0] cnt_inc;
  hole_lim_t        lim;
  cell_ctl_t        cctl;
  logic             load_sym;

  logic [SYM_W-1:0] wnd [PATTERN_MAX];
  logic [SYM_W-1:0] pf_q, pr_q;
  logic [AW-1:0]    raddr_f, raddr_r, waddr;
  logic             pat_we;
  logic [LW-1:0]    fidx;

  // Active length: zero acts as one, clamp at the store depth.
  always_comb begin
    len32 = 32'(plen_r);
    if (len32 == '0) begin
      len32 = 32'd1;
    end else if (len32 > 32'(PATTERN_MAX)) begin
      len32 = 32'(PATTERN_MAX);
    end
  end
  assign len_l = LW'(len32);

  assign acc     = in_ch.valid && in_ch.ready;
  assign acc_seq = acc && (in_ch.func == FUNC_SEQUENCE);
  assign acc_pat = acc && (in_ch.func == FUNC_PATTERN);

  assign seen_base = in_ch.new_sequence ? '0 : seen_r;
  assign seen_nxt  = acc_seq ? ((seen_base == CNT_MAX) ? seen_base : seen_base + 32'd1)
                             : seen_r;
  assign win_full  = seen_nxt >= len32;
  assign k_last    = (k_r == len_l - LW'(1));
  assign cnt_inc   = (matches_r == CNT_MAX) ? matches_r : matches_r + 32'd1;
  assign lim       = '{run_count_lim: mh_r, max_hole_len: mhl_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc_seq && win_full) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (k_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_RESTORE;
      ST_RESTORE: begin
        if (k_last) begin
          state_nxt = (!fail_f || !fail_r) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_v_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready   = 1'b0;
    cctl          = '{shift_up: 1'b0, shift_dn: 1'b0};
    load_sym      = 1'b0;
    k_nxt         = k_r;
    cmp_v_nxt     = 1'b0;
    trk_clear     = 1'b0;
    load_out      = 1'b0;
    pos_nxt       = pos_r;
    matches_nxt   = matches_r;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (acc_seq) begin
          cctl.shift_up = 1'b1;
          load_sym      = 1'b1;
          k_nxt         = '0;
          trk_clear     = 1'b1;
          pos_nxt       = seen_nxt - len32;
          if (in_ch.new_sequence) begin
            matches_nxt = '0;
          end
        end
      end
      ST_CMP: begin
        cctl.shift_dn = 1'b1;
        cmp_v_nxt     = 1'b1;
        k_nxt         = k_last ? '0 : k_r + LW'(1);
      end
      ST_DRAIN: begin
        k_nxt = '0;
      end
      ST_RESTORE: begin
        cctl.shift_up = 1'b1;
        k_nxt         = k_r + LW'(1);
      end
      ST_EMIT: begin
        if (!out_v_r || out_ch.ready) begin
          load_out    = 1'b1;
          matches_nxt = cnt_inc;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_v_nxt = load_out ? 1'b1 : (out_v_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      plen_r    <= CFG_W'(1);
      mh_r      <= '0;
      mhl_r     <= '0;
      seen_r    <= '0;
      matches_r <= '0;
      k_r       <= '0;
      cmp_v_r   <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      seen_r    <= seen_nxt;
      matches_r <= matches_nxt;
      k_r       <= k_nxt;
      cmp_v_r   <= cmp_v_nxt;
      out_v_r   <= out_v_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_PATTERN_LENGTH: plen_r <= cfg_data;
          REG_MAX_HOLES:      mh_r   <= cfg_data;
          REG_MAX_HOLE_LEN:   mhl_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    tap_r <= wnd[0];
    if (load_out) begin
      out_pos_r <= pos_r;
      out_fwd_r <= !fail_f;
      out_rev_r <= !fail_r;
      out_cnt_r <= cnt_inc;
    end
  end

  // Window ring: cell 0 holds the newest symbol; shift_dn walks it past cell 0.
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic [SYM_W-1:0] lo, hi;
    if (i == 0) begin : g_first
      assign lo = load_sym ? in_ch.symbol : wnd[PATTERN_MAX-1];
    end else begin : g_mid
      assign lo = wnd[i-1];
    end
    if (i == PATTERN_MAX - 1) begin : g_last
      assign hi = wnd[0];
    end else begin : g_inner
      assign hi = wnd[i+1];
    end
    dhm_cell u_cell (
      .clk   (clk),
      .ctl   (cctl),
      .lo_in (lo),
      .hi_in (hi),
      .q     (wnd[i])
    );
  end

  // Window entry k meets pattern[L-1-k] forward and pattern[k] reversed.
  assign fidx    = len_l - LW'(1) - k_r;
  assign raddr_f = fidx[AW-1:0];
  assign raddr_r = k_r[AW-1:0];
  assign pat_we  = acc_pat && (32'(in_ch.pattern_index) < 32'(PATTERN_MAX));
  assign waddr   = AW'(in_ch.pattern_index);

  dhm_ram #(.W(SYM_W), .D(PATTERN_MAX)) u_pat_fwd (
    .clk   (clk),
    .we    (pat_we),
    .waddr (waddr),
    .wdata (in_ch.symbol),
    .raddr (raddr_f),
    .rdata (pf_q)
  );

  dhm_ram #(.W(SYM_W), .D(PATTERN_MAX)) u_pat_rev (
    .clk   (clk),
    .we    (pat_we),
    .waddr (waddr),
    .wdata (in_ch.symbol),
    .raddr (raddr_r),
    .rdata (pr_q)
  );

  dhm_hole #(.LW(LW)) u_hole_fwd (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (trk_clear),
    .valid    (cmp_v_r),
    .mismatch (tap_r != pf_q),
    .lim      (lim),
    .fail     (fail_f)
  );

  dhm_hole #(.LW(LW)) u_hole_rev (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (trk_clear),
    .valid    (cmp_v_r),
    .mismatch (tap_r != pr_q),
    .lim      (lim),
    .fail     (fail_r)
  );

  assign out_ch.valid          = out_v_r;
  assign out_ch.match_position = out_pos_r;
  assign out_ch.forward_hit    = out_fwd_r;
  assign out_ch.reverse_hit    = out_rev_r;
  assign out_ch.match_count    = out_cnt_r;

  `DHM_ASSERT(a_hit_kind, !out_v_r || out_fwd_r || out_rev_r, "result without a hit")
  `DHM_ASSERT(a_count_nz, !out_v_r || out_cnt_r != '0, "result with zero match count")
  `DHM_ASSERT(a_cmp_range, state_r != ST_CMP || k_r < len_l, "compare index past window")
  `DHM_ASSERT_NEXT(a_pat_idle, acc_pat, state_r == ST_IDLE, "pattern write left idle")
endmodule

[bench/dhm_tb_if.sv]
`timescale 1ns / 100ps
// Channel interfaces come from the RTL folder; nothing else is needed here.

[bench/tb.sv]
`timescale 1ns / 100ps
module tb;
  import dhm_pkg::*;

  localparam int PMAX = PATTERN_MAX_DEF;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic func;
    logic [IDX_W-1:0] idx;
    logic [SYM_W-1:0] sym;
    logic restart;
  } symbol_txn_t;

  typedef struct packed {
    logic [CNT_W-1:0] pos;
    logic fwd;
    logic rev;
    logic [CNT_W-1:0] cnt;
  } hit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = REG_PATTERN_LENGTH;
  logic [CFG_W-1:0] cfg_data = '0;

  dhm_in_if in_ch ();
  dhm_out_if out_ch ();

  dna_hole_tolerant_pattern_matcher dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [SYM_W-1:0] pat_mem [PMAX];
  logic [SYM_W-1:0] recent [PMAX];
  logic [CNT_W-1:0] seen_cnt = '0;
  logic [CNT_W-1:0] hit_cnt = '0;
  logic [CFG_W-1:0] len_reg = 11'd1;
  logic [CFG_W-1:0] holes_reg = '0;
  logic [CFG_W-1:0] hole_len_reg = '0;

  symbol_txn_t send_q [$];
  hit_t hits_q [$];
  int unsigned pushed = 0;
  int unsigned accepted = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  function automatic int unsigned eff_len();
    if (len_reg == 0) return 1;
    if (len_reg > PMAX) return PMAX;
    return 32'(len_reg);
  endfunction

  function automatic logic window_matches(int unsigned len, logic reversed);
    int unsigned run;
    int unsigned runs;
    logic [SYM_W-1:0] p;
    run = 0;
    runs = 0;
    for (int unsigned j = 0; j < len; j++) begin
      p = reversed ? pat_mem[len-1-j] : pat_mem[j];
      if (recent[len-1-j] != p) begin
        run++;
        if (run == 1) runs++;
        if (run > hole_len_reg || runs > holes_reg) return 1'b0;
      end else begin
        run = 0;
      end
    end
    return 1'b1;
  endfunction

  task automatic track_symbol(symbol_txn_t t);
    int unsigned len;
    hit_t h;
    if (t.func == FUNC_PATTERN) begin
      pat_mem[t.idx] = t.sym;
      return;
    end
    if (t.restart) begin
      seen_cnt = '0;
      hit_cnt = '0;
    end
    for (int k = PMAX - 1; k > 0; k--) recent[k] = recent[k-1];
    recent[0] = t.sym;
    if (seen_cnt != CNT_MAX) seen_cnt++;
    len = eff_len();
    if (seen_cnt < len) return;
    h.fwd = window_matches(len, 1'b0);
    h.rev = window_matches(len, 1'b1);
    if (!h.fwd && !h.rev) return;
    if (hit_cnt != CNT_MAX) hit_cnt++;
    h.pos = seen_cnt - len;
    h.cnt = hit_cnt;
    hits_q.push_back(h);
  endtask

  task automatic report(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (send_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        symbol_txn_t t;
        t = send_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.func <= t.func;
        in_ch.pattern_index <= t.idx;
        in_ch.symbol <= t.sym;
        in_ch.new_sequence <= t.restart;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("dna_hole_tolerant_pattern_matcher test failed");
      $finish;
    end
    out_ch.ready <= rst_n && ($urandom_range(0, 99) >= stall_pct);
    if (rst_n && in_ch.valid && in_ch.ready) begin
      symbol_txn_t t;
      t.func = in_ch.func;
      t.idx = in_ch.pattern_index;
      t.sym = in_ch.symbol;
      t.restart = in_ch.new_sequence;
      track_symbol(t);
      accepted++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      hit_t e;
      if (hits_q.size() == 0) begin
        report($sformatf("unexpected hit at position %0d", out_ch.match_position));
      end else begin
        e = hits_q.pop_front();
        if (out_ch.match_position !== e.pos)
          report($sformatf("position %0d, want %0d", out_ch.match_position, e.pos));
        if (out_ch.forward_hit !== e.fwd)
          report($sformatf("forward %0b, want %0b at %0d", out_ch.forward_hit, e.fwd, e.pos));
        if (out_ch.reverse_hit !== e.rev)
          report($sformatf("reverse %0b, want %0b at %0d", out_ch.reverse_hit, e.rev, e.pos));
        if (out_ch.match_count !== e.cnt)
          report($sformatf("count %0d, want %0d at %0d", out_ch.match_count, e.cnt, e.pos));
      end
    end
  end

  task automatic push(logic func, int unsigned idx, int unsigned sym, logic restart);
    symbol_txn_t t;
    t.func = func;
    t.idx = IDX_W'(idx);
    t.sym = SYM_W'(sym);
    t.restart = restart;
    send_q.push_back(t);
    pushed++;
  endtask

  // wait for all transactions and hits, then for a possible hitless compare
  task automatic settle();
    while (accepted != pushed || hits_q.size() != 0) @(posedge clk);
    repeat (2 * eff_len() + 10) @(posedge clk);
  endtask

  task automatic configure(int unsigned len, int unsigned holes, int unsigned hole_len,
                           int phase);
    case (phase % 4)
      0: begin idle_pct = 0; stall_pct = 0; end
      1: begin idle_pct = 51; stall_pct = 0; end
      2: begin idle_pct = 0; stall_pct = 51; end
      default: begin idle_pct = 19; stall_pct = 19; end
    endcase
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= REG_PATTERN_LENGTH; cfg_data <= CFG_W'(len);
    len_reg = CFG_W'(len);
    @(posedge clk);
    cfg_index <= REG_MAX_HOLES; cfg_data <= CFG_W'(holes);
    holes_reg = CFG_W'(holes);
    @(posedge clk);
    cfg_index <= REG_MAX_HOLE_LEN; cfg_data <= CFG_W'(hole_len);
    hole_len_reg = CFG_W'(hole_len);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one sequence built from the pattern, mutated at mut_pct percent
  task automatic gen_sequence(int unsigned n, int unsigned mut_pct);
    int unsigned len;
    logic reversed;
    int unsigned pos;
    int unsigned sym;
    len = eff_len();
    reversed = 1'($urandom_range(0, 1));
    for (int unsigned k = 0; k < n; k++) begin
      pos = k % len;
      sym = reversed ? 32'(pat_mem[len-1-pos]) : 32'(pat_mem[pos]);
      if ($urandom_range(0, 99) < mut_pct) sym = $urandom_range(0, 3);
      push(FUNC_SEQUENCE, $urandom_range(0, PMAX - 1), sym, k == 0);
      // occasional pattern rewrite inside the stream
      if ($urandom_range(0, 99) < 2) push(FUNC_PATTERN, $urandom_range(0, len - 1),
                                        $urandom_range(0, 3), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int phase;
    int unsigned len;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_PATTERN;
    in_ch.pattern_index = '0;
    in_ch.symbol = '0;
    in_ch.new_sequence = 1'b0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < PMAX; i++) begin
      pat_mem[i] = '0;
      recent[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: a length of zero acts as one, extremes of index and symbol
    configure(0, 0, 0, 0);
    for (int i = 0; i < 64; i++) push(FUNC_PATTERN, i, $urandom_range(0, 3), 1'b0);
    push(FUNC_PATTERN, 1023, 2'd3, 1'b1);
    push(FUNC_PATTERN, 0, 2'd0, 1'b1);
    for (int s = 0; s < 4; s++) push(FUNC_SEQUENCE, 1023, s, s == 0);
    push(FUNC_SEQUENCE, 0, 2'd0, 1'b1);
    push(FUNC_SEQUENCE, 0, 2'd0, 1'b0);
    settle();
    configure(4, 2047, 2047, 1);
    for (int s = 0; s < 8; s++) push(FUNC_SEQUENCE, 0, s % 4, s == 0);
    push(FUNC_SEQUENCE, 0, 2'd1, 1'b0);
    settle();
    configure(3, 0, 0, 2);
    gen_sequence(9, 0);
    push(FUNC_SEQUENCE, 0, 2'd2, 1'b1);
    push(FUNC_SEQUENCE, 0, 2'd2, 1'b0);
    settle();

    // random phases, mostly short patterns so hits are frequent
    phase = 3;
    while (pushed < 1250) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      configure(len, $urandom_range(0, 3), $urandom_range(0, 3), phase);
      for (int r = 0; r < 4; r++) begin
        if ($urandom_range(0, 4) == 0) begin
          // noise
          for (int k = 0; k < 20; k++)
            push(FUNC_SEQUENCE, $urandom_range(0, PMAX - 1), $urandom_range(0, 3),
                 $urandom_range(0, 19) == 0);
        end else begin
          gen_sequence($urandom_range(len, 3 * len + 4), $urandom_range(0, 15));
        end
      end
      settle();
      phase++;
    end

    if (errors == 0) begin
      $display("dna_hole_tolerant_pattern_matcher test passed");
    end else begin
      $display("dna_hole_tolerant_pattern_matcher test failed");
    end
    $finish;
  end
endmodule
